// ----- rtl/cl_pkg.sv -----
package cl_pkg;

    localparam int MAX_PARTICLES  = 1024;
    localparam int PIDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W          = PIDX_W + 1;
    localparam int MAX_CELLS      = 4096;
    localparam int HASH_W         = $clog2(MAX_CELLS);
    localparam int NEIGHBOR_LIMIT = 64;
    localparam int ORD_W          = 7;
    localparam int POS_W          = 20;
    localparam int GRID_W         = 5;
    localparam int GRID_MAX       = 16;
    localparam int COORD_W        = 4;
    localparam int SQ_W           = 2 * POS_W;
    localparam int SUM_W          = SQ_W + 2;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_CELL_SIZE = 2'd0,
        REG_GRID_X    = 2'd1,
        REG_GRID_Y    = 2'd2,
        REG_GRID_Z    = 2'd3
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_HREAD,
        S_HDIV,
        S_HWAIT,
        S_HINC,
        S_PFX_RD,
        S_PFX_WR,
        S_SC_RD,
        S_SC_H,
        S_SC_W,
        S_QDIV,
        S_QWAIT,
        S_CELL,
        S_RANGE,
        S_CAND,
        S_QID,
        S_DIFF,
        S_SQ,
        S_SUM,
        S_FIN
    } t_state;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
    } t_div_res;

    // Grid dimensions are clamped to the range 1..GRID_MAX.
    function automatic logic [GRID_W-1:0] grid_eff(input logic [GRID_W-1:0] g);
        logic [GRID_W-1:0] r;
        if (g == '0) begin
            r = GRID_W'(1);
        end else if (g > GRID_W'(GRID_MAX)) begin
            r = GRID_W'(GRID_MAX);
        end else begin
            r = g;
        end
        return r;
    endfunction

    function automatic logic [HASH_W-1:0] cell_hash(
        input logic [COORD_W-1:0] cx,
        input logic [COORD_W-1:0] cy,
        input logic [COORD_W-1:0] cz,
        input logic [GRID_W-1:0]  gx,
        input logic [GRID_W-1:0]  gy
    );
        logic [HASH_W+1:0] t;
        t = (HASH_W+2)'(cz) * (HASH_W+2)'(gx) * (HASH_W+2)'(gy)
          + (HASH_W+2)'(cy) * (HASH_W+2)'(gx) + (HASH_W+2)'(cx);
        return t[HASH_W-1:0];
    endfunction

endpackage

// ----- rtl/cl_ram.sv -----
module cl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cl_div.sv -----
// Cell coordinate unit: floor(pos / cell_size) for three axes at once,
// one quotient bit per cycle, saturated to grid size - 1.
module cl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cl_pkg::POS_W-1:0]    i_pos_x,
    input  logic [cl_pkg::POS_W-1:0]    i_pos_y,
    input  logic [cl_pkg::POS_W-1:0]    i_pos_z,
    input  logic [cl_pkg::POS_W-1:0]    i_cell_size,
    input  logic [cl_pkg::GRID_W-1:0]   i_gx,
    input  logic [cl_pkg::GRID_W-1:0]   i_gy,
    input  logic [cl_pkg::GRID_W-1:0]   i_gz,
    output cl_pkg::t_div_res            o_res
);

    localparam int CW = cl_pkg::COORD_W;
    localparam int WW = cl_pkg::POS_W + CW;
    localparam int BW = $clog2(CW);

    logic [cl_pkg::POS_W-1:0]  w_pos [3];
    logic [cl_pkg::GRID_W-1:0] w_g   [3];
    logic [cl_pkg::POS_W-1:0]  r_rem [3];
    logic [CW-1:0]             r_q   [3];
    logic [CW-1:0]             r_gm1 [3];
    logic [CW-1:0]             w_c   [3];
    logic [2:0]                r_sat;
    logic [cl_pkg::POS_W-1:0]  r_cs;
    logic [BW-1:0]             r_b;
    logic                      r_busy;
    logic                      r_done;
    logic [WW-1:0]             w_shift;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;
    assign w_g[0]   = i_gx;
    assign w_g[1]   = i_gy;
    assign w_g[2]   = i_gz;
    assign w_shift  = WW'(r_cs) << r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_b    <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_b == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_b    <= BW'(CW - 1);
            end else if (r_busy) begin
                r_b <= r_b - 1'b1;
                if (r_b == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cs <= i_cell_size;
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= w_pos[k];
                r_q[k]   <= '0;
                r_sat[k] <= WW'(w_pos[k]) >= {i_cell_size, CW'(0)};
                r_gm1[k] <= CW'(w_g[k] - 1'b1);
            end
        end else if (r_busy) begin
            for (int k = 0; k < 3; k++) begin
                if (WW'(r_rem[k]) >= w_shift) begin
                    r_rem[k]      <= r_rem[k] - w_shift[cl_pkg::POS_W-1:0];
                    r_q[k][r_b]   <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_c[k] = r_sat[k] ? '1 : r_q[k];
            if (w_c[k] > r_gm1[k]) begin
                w_c[k] = r_gm1[k];
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.cx   = w_c[0];
    assign o_res.cy   = w_c[1];
    assign o_res.cz   = w_c[2];

endmodule

// ----- rtl/cell_list_neighbor_search_core.sv -----
// Load writes one position. Build clears the cell table, hashes each particle, runs a
// prefix sum over the cell table and scatters each particle. Neither gives a result.
// Query: it finds the particle's cell, then walks the cells around it, skipping cells
// outside the grid and the particle itself; a result leaves, registered, at the next hit,
// the last after the walk. One transaction at a time; results cannot be stalled. Synchronous
// reset clears control and config; datapath and memories are undefined until written.
module cell_list_neighbor_search_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [10:0]                   i_particle_index,
    input  logic [cl_pkg::POS_W-1:0]      i_pos_x,
    input  logic [cl_pkg::POS_W-1:0]      i_pos_y,
    input  logic [cl_pkg::POS_W-1:0]      i_pos_z,
    output logic                          o_result_valid,
    output logic [9:0]                    o_nbr_index,
    output logic [6:0]                    o_neighbor_ordinal,
    output logic                          o_found,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cl_pkg::PADDR_W-1:0]    paddr,
    input  logic [cl_pkg::PDATA_W-1:0]    pwdata,
    output logic [cl_pkg::PDATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int PW  = cl_pkg::POS_W;
    localparam int IW  = cl_pkg::PIDX_W;
    localparam int CNW = cl_pkg::CNT_W;
    localparam int HW  = cl_pkg::HASH_W;
    localparam int GW  = cl_pkg::GRID_W;
    localparam int CW  = cl_pkg::COORD_W;
    localparam int OW  = cl_pkg::ORD_W;

    cl_pkg::t_state r_state, n_state;

    logic [PW-1:0]  r_cell_size;
    logic [GW-1:0]  r_gx, r_gy, r_gz;
    logic [CNW-1:0] r_total, r_n, r_i, r_acc, r_j, r_jend;
    logic [HW-1:0]  r_c, r_h;
    logic [IW-1:0]  r_qidx, r_q, r_pend;
    logic [PW-1:0]  r_px, r_py, r_pz, r_ax, r_ay, r_az;
    logic [cl_pkg::SQ_W-1:0] r_r2, r_sqx, r_sqy, r_sqz;
    logic [CW-1:0]  r_cx, r_cy, r_cz;
    logic [1:0]     r_dx, r_dy, r_dz;
    logic           r_cells_done, r_near, r_have;
    logic [OW-1:0]  r_count, r_pend_ord;
    logic           r_ov, r_ofound, r_olast;
    logic [IW-1:0]  r_oidx;
    logic [OW-1:0]  r_oord;

    logic           w_acc, w_cfg_wr, w_cell_ok, w_hit, w_adv;
    logic [GW-1:0]  w_gx, w_gy, w_gz;
    logic [PW-1:0]  w_cs_div;
    logic [5:0]     w_tx, w_ty, w_tz;
    logic [CW-1:0]  w_nx, w_ny, w_nz;
    logic [HW-1:0]  w_nh, w_bh;
    logic [cl_pkg::SUM_W-1:0] w_sum;
    logic [PW-1:0]  w_qx, w_qy, w_qz;
    cl_pkg::t_div_res w_div;
    logic           w_div_start;

    // Memory ports.
    logic              pos_we;
    logic [IW-1:0]     pos_waddr, pos_raddr;
    logic [3*PW-1:0]   pos_wdata, pos_rdata;
    logic              hash_we;
    logic [IW-1:0]     hash_addr;
    logic [HW-1:0]     hash_rdata;
    logic              sort_we;
    logic [IW-1:0]     sort_waddr, sort_raddr;
    logic [IW-1:0]     sort_rdata;
    logic              cs_we;
    logic [HW-1:0]     cs_raddr;
    logic [CNW-1:0]    cs_rdata;
    logic              ce_we;
    logic [HW-1:0]     ce_waddr, ce_raddr;
    logic [CNW-1:0]    ce_wdata, ce_rdata;

    assign w_acc    = start && !busy;
    assign busy     = r_state != cl_pkg::S_IDLE;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign w_gx     = cl_pkg::grid_eff(r_gx);
    assign w_gy     = cl_pkg::grid_eff(r_gy);
    assign w_gz     = cl_pkg::grid_eff(r_gz);
    assign w_cs_div = (r_cell_size == '0) ? PW'(1) : r_cell_size;

    always_comb begin
        case (paddr[3:2])
            cl_pkg::REG_CELL_SIZE: prdata = cl_pkg::PDATA_W'(r_cell_size);
            cl_pkg::REG_GRID_X:    prdata = cl_pkg::PDATA_W'(r_gx);
            cl_pkg::REG_GRID_Y:    prdata = cl_pkg::PDATA_W'(r_gy);
            cl_pkg::REG_GRID_Z:    prdata = cl_pkg::PDATA_W'(r_gz);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= PW'(1024);
            r_gx        <= GW'(16);
            r_gy        <= GW'(16);
            r_gz        <= GW'(16);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                cl_pkg::REG_CELL_SIZE: r_cell_size <= pwdata[PW-1:0];
                cl_pkg::REG_GRID_X:    r_gx        <= pwdata[GW-1:0];
                cl_pkg::REG_GRID_Y:    r_gy        <= pwdata[GW-1:0];
                cl_pkg::REG_GRID_Z:    r_gz        <= pwdata[GW-1:0];
                default:               r_gx        <= r_gx;
            endcase
        end
    end

    // Neighbor cell of the walk: offsets are stored as 0..2 and mean -1..1.
    assign w_tx = 6'(r_cx) + 6'(r_dx);
    assign w_ty = 6'(r_cy) + 6'(r_dy);
    assign w_tz = 6'(r_cz) + 6'(r_dz);
    assign w_nx = CW'(w_tx - 6'd1);
    assign w_ny = CW'(w_ty - 6'd1);
    assign w_nz = CW'(w_tz - 6'd1);
    assign w_cell_ok = (w_tx != '0) && (w_tx <= 6'(w_gx))
                    && (w_ty != '0) && (w_ty <= 6'(w_gy))
                    && (w_tz != '0) && (w_tz <= 6'(w_gz));
    assign w_nh = cl_pkg::cell_hash(w_nx, w_ny, w_nz, w_gx, w_gy);
    assign w_bh = cl_pkg::cell_hash(w_div.cx, w_div.cy, w_div.cz, w_gx, w_gy);

    assign w_qx  = pos_rdata[PW-1:0];
    assign w_qy  = pos_rdata[2*PW-1:PW];
    assign w_qz  = pos_rdata[3*PW-1:2*PW];
    assign w_sum = cl_pkg::SUM_W'(r_sqx) + cl_pkg::SUM_W'(r_sqy) + cl_pkg::SUM_W'(r_sqz);
    assign w_hit = r_near && (w_sum < cl_pkg::SUM_W'(r_r2));
    assign w_adv = (r_state == cl_pkg::S_RANGE)
                || (r_state == cl_pkg::S_CELL && !r_cells_done && !w_cell_ok);
    assign w_div_start = (r_state == cl_pkg::S_HDIV) || (r_state == cl_pkg::S_QDIV);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cl_pkg::S_IDLE: begin
                if (w_acc) begin
                    case (i_opcode)
                        cl_pkg::OP_BUILD: n_state = cl_pkg::S_CLR;
                        cl_pkg::OP_QUERY: n_state = (i_particle_index < r_total)
                                                  ? cl_pkg::S_QDIV : cl_pkg::S_FIN;
                        default:          n_state = cl_pkg::S_IDLE;
                    endcase
                end
            end
            cl_pkg::S_CLR:    if (r_c == '1) n_state = cl_pkg::S_HREAD;
            cl_pkg::S_HREAD:  n_state = (r_i == r_n) ? cl_pkg::S_PFX_RD : cl_pkg::S_HDIV;
            cl_pkg::S_HDIV:   n_state = cl_pkg::S_HWAIT;
            cl_pkg::S_HWAIT:  if (w_div.done) n_state = cl_pkg::S_HINC;
            cl_pkg::S_HINC:   n_state = cl_pkg::S_HREAD;
            cl_pkg::S_PFX_RD: n_state = cl_pkg::S_PFX_WR;
            cl_pkg::S_PFX_WR: n_state = (r_c == '1) ? cl_pkg::S_SC_RD : cl_pkg::S_PFX_RD;
            cl_pkg::S_SC_RD:  n_state = (r_i == r_n) ? cl_pkg::S_IDLE : cl_pkg::S_SC_H;
            cl_pkg::S_SC_H:   n_state = cl_pkg::S_SC_W;
            cl_pkg::S_SC_W:   n_state = cl_pkg::S_SC_RD;
            cl_pkg::S_QDIV:   n_state = cl_pkg::S_QWAIT;
            cl_pkg::S_QWAIT:  if (w_div.done) n_state = cl_pkg::S_CELL;
            cl_pkg::S_CELL: begin
                if (r_cells_done) begin
                    n_state = cl_pkg::S_FIN;
                end else if (w_cell_ok) begin
                    n_state = cl_pkg::S_RANGE;
                end
            end
            cl_pkg::S_RANGE:  n_state = cl_pkg::S_CAND;
            cl_pkg::S_CAND:   n_state = (r_j >= r_jend || r_j[IW])
                                      ? cl_pkg::S_CELL : cl_pkg::S_QID;
            cl_pkg::S_QID:    n_state = (sort_rdata == r_qidx) ? cl_pkg::S_CAND : cl_pkg::S_DIFF;
            cl_pkg::S_DIFF:   n_state = cl_pkg::S_SQ;
            cl_pkg::S_SQ:     n_state = cl_pkg::S_SUM;
            cl_pkg::S_SUM:    n_state = (w_hit && r_count == OW'(cl_pkg::NEIGHBOR_LIMIT - 1))
                                      ? cl_pkg::S_FIN : cl_pkg::S_CAND;
            cl_pkg::S_FIN:    n_state = cl_pkg::S_IDLE;
            default:          n_state = cl_pkg::S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        pos_we     = 1'b0;
        pos_waddr  = i_particle_index[IW-1:0];
        pos_wdata  = {i_pos_z, i_pos_y, i_pos_x};
        pos_raddr  = i_particle_index[IW-1:0];
        hash_we    = 1'b0;
        hash_addr  = r_i[IW-1:0];
        sort_we    = 1'b0;
        sort_waddr = ce_rdata[IW-1:0];
        sort_raddr = r_j[IW-1:0];
        cs_we      = 1'b0;
        cs_raddr   = w_nh;
        ce_we      = 1'b0;
        ce_waddr   = r_c;
        ce_wdata   = '0;
        ce_raddr   = w_nh;
        case (r_state)
            cl_pkg::S_IDLE: begin
                pos_we = w_acc && (i_opcode == cl_pkg::OP_LOAD) && !i_particle_index[IW];
            end
            cl_pkg::S_CLR:   ce_we = 1'b1;
            cl_pkg::S_HREAD: pos_raddr = r_i[IW-1:0];
            cl_pkg::S_HWAIT: begin
                hash_we  = w_div.done;
                ce_raddr = w_bh;
            end
            cl_pkg::S_HINC: begin
                ce_we    = 1'b1;
                ce_waddr = r_h;
                ce_wdata = ce_rdata + 1'b1;
            end
            cl_pkg::S_PFX_RD: ce_raddr = r_c;
            cl_pkg::S_PFX_WR: begin
                cs_we    = 1'b1;
                ce_we    = 1'b1;
                ce_wdata = r_acc;
            end
            cl_pkg::S_SC_H: ce_raddr = hash_rdata;
            cl_pkg::S_SC_W: begin
                sort_we  = 1'b1;
                ce_we    = 1'b1;
                ce_waddr = r_h;
                ce_wdata = ce_rdata + 1'b1;
            end
            cl_pkg::S_QID: pos_raddr = sort_rdata;
            default: pos_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cl_pkg::S_IDLE;
            r_total <= '0;
            r_ov    <= 1'b0;
            r_count <= '0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= (r_state == cl_pkg::S_FIN)
                    || (r_state == cl_pkg::S_SUM && w_hit && r_have);
            if (r_state == cl_pkg::S_IDLE && w_acc && i_opcode == cl_pkg::OP_BUILD) begin
                r_total <= (i_particle_index > CNW'(cl_pkg::MAX_PARTICLES))
                         ? CNW'(cl_pkg::MAX_PARTICLES) : i_particle_index;
            end
            if (r_state == cl_pkg::S_IDLE && w_acc && i_opcode == cl_pkg::OP_QUERY) begin
                r_count <= '0;
                r_have  <= 1'b0;
            end
            if (r_state == cl_pkg::S_SUM && w_hit) begin
                r_oidx   <= r_pend;
                r_oord   <= r_pend_ord;
                r_ofound <= 1'b1;
                r_olast  <= 1'b0;
                r_pend     <= r_q;
                r_pend_ord <= r_count + 1'b1;
                r_count    <= r_count + 1'b1;
                r_have     <= 1'b1;
            end
            if (r_state == cl_pkg::S_FIN) begin
                r_oidx   <= r_have ? r_pend : '0;
                r_oord   <= r_have ? r_pend_ord : '0;
                r_ofound <= r_have;
                r_olast  <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            cl_pkg::S_IDLE: begin
                r_n          <= (i_particle_index > CNW'(cl_pkg::MAX_PARTICLES))
                              ? CNW'(cl_pkg::MAX_PARTICLES) : i_particle_index;
                r_i          <= '0;
                r_c          <= '0;
                r_acc        <= '0;
                r_qidx       <= i_particle_index[IW-1:0];
                r_dx         <= '0;
                r_dy         <= '0;
                r_dz         <= '0;
                r_cells_done <= 1'b0;
            end
            cl_pkg::S_CLR:   r_c <= r_c + 1'b1;
            cl_pkg::S_HWAIT: r_h <= w_bh;
            cl_pkg::S_HINC:  r_i <= r_i + 1'b1;
            cl_pkg::S_PFX_WR: begin
                r_acc <= r_acc + ce_rdata;
                r_c   <= r_c + 1'b1;
                r_i   <= '0;
            end
            cl_pkg::S_SC_H:  r_h <= hash_rdata;
            cl_pkg::S_SC_W:  r_i <= r_i + 1'b1;
            cl_pkg::S_QDIV: begin
                r_px <= w_qx;
                r_py <= w_qy;
                r_pz <= w_qz;
                r_r2 <= r_cell_size * r_cell_size;
            end
            cl_pkg::S_QWAIT: begin
                r_cx <= w_div.cx;
                r_cy <= w_div.cy;
                r_cz <= w_div.cz;
            end
            cl_pkg::S_RANGE: begin
                r_j    <= cs_rdata;
                r_jend <= ce_rdata;
            end
            cl_pkg::S_CAND:  r_j <= r_j + 1'b1;
            cl_pkg::S_QID:   r_q <= sort_rdata;
            cl_pkg::S_DIFF: begin
                r_ax   <= (r_px > w_qx) ? r_px - w_qx : w_qx - r_px;
                r_ay   <= (r_py > w_qy) ? r_py - w_qy : w_qy - r_py;
                r_az   <= (r_pz > w_qz) ? r_pz - w_qz : w_qz - r_pz;
            end
            cl_pkg::S_SQ: begin
                r_near <= (r_ax < r_cell_size) && (r_ay < r_cell_size) && (r_az < r_cell_size);
                r_sqx  <= r_ax * r_ax;
                r_sqy  <= r_ay * r_ay;
                r_sqz  <= r_az * r_az;
            end
            default: r_h <= r_h;
        endcase
        if (w_adv) begin
            r_dx <= (r_dx == 2'd2) ? 2'd0 : r_dx + 1'b1;
            if (r_dx == 2'd2) begin
                r_dy <= (r_dy == 2'd2) ? 2'd0 : r_dy + 1'b1;
                if (r_dy == 2'd2) begin
                    r_dz <= (r_dz == 2'd2) ? 2'd0 : r_dz + 1'b1;
                    if (r_dz == 2'd2) begin
                        r_cells_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_result_valid     = r_ov;
    assign o_nbr_index        = r_oidx;
    assign o_neighbor_ordinal = r_oord;
    assign o_found            = r_ofound;
    assign o_last             = r_olast;

    cl_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_pos_x     (w_qx),
        .i_pos_y     (w_qy),
        .i_pos_z     (w_qz),
        .i_cell_size (w_cs_div),
        .i_gx        (w_gx),
        .i_gy        (w_gy),
        .i_gz        (w_gz),
        .o_res       (w_div)
    );

    cl_ram #(.WIDTH(3 * PW), .DEPTH(cl_pkg::MAX_PARTICLES)) u_pos_ram (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pos_raddr), .o_rdata(pos_rdata)
    );

    cl_ram #(.WIDTH(HW), .DEPTH(cl_pkg::MAX_PARTICLES)) u_hash_ram (
        .i_clk(i_clk), .i_we(hash_we), .i_waddr(hash_addr), .i_wdata(w_bh),
        .i_raddr(hash_addr), .o_rdata(hash_rdata)
    );

    cl_ram #(.WIDTH(IW), .DEPTH(cl_pkg::MAX_PARTICLES)) u_sort_ram (
        .i_clk(i_clk), .i_we(sort_we), .i_waddr(sort_waddr), .i_wdata(r_i[IW-1:0]),
        .i_raddr(sort_raddr), .o_rdata(sort_rdata)
    );

    cl_ram #(.WIDTH(CNW), .DEPTH(cl_pkg::MAX_CELLS)) u_start_ram (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(r_c), .i_wdata(r_acc),
        .i_raddr(cs_raddr), .o_rdata(cs_rdata)
    );

    cl_ram #(.WIDTH(CNW), .DEPTH(cl_pkg::MAX_CELLS)) u_end_ram (
        .i_clk(i_clk), .i_we(ce_we), .i_waddr(ce_waddr), .i_wdata(ce_wdata),
        .i_raddr(ce_raddr), .o_rdata(ce_rdata)
    );

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_found) |-> o_last)
        else $error("empty result without last flag");

    a_ordinal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_found) |->
        (o_neighbor_ordinal != '0 && o_neighbor_ordinal <= OW'(cl_pkg::NEIGHBOR_LIMIT)))
        else $error("neighbor ordinal out of range");

    a_work_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == cl_pkg::OP_BUILD || i_opcode == cl_pkg::OP_QUERY))
        |=> busy)
        else $error("build or query accepted without going busy");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OW'(cl_pkg::NEIGHBOR_LIMIT))
        else $error("neighbor count exceeded limit");

endmodule

// ----- tb/sv/cell_list_neighbor_search_core_tb.sv -----
`timescale 1ns / 1ps

module cell_list_neighbor_search_core_tb;
    import cl_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        t_opcode     op;
        logic [10:0] idx;
        logic [19:0] px;
        logic [19:0] py;
        logic [19:0] pz;
    } t_cmd;

    typedef struct {
        logic [9:0] nbr;
        logic [6:0] ord;
        logic       found;
        logic       last;
    } t_hit;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [10:0] i_particle_index;
    logic [19:0] i_pos_x, i_pos_y, i_pos_z;
    logic        o_result_valid;
    logic [9:0]  o_nbr_index;
    logic [6:0]  o_neighbor_ordinal;
    logic        o_found, o_last;
    logic        psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic        pready;

    cell_list_neighbor_search_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_particle_index(i_particle_index),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .o_result_valid(o_result_valid), .o_nbr_index(o_nbr_index),
        .o_neighbor_ordinal(o_neighbor_ordinal), .o_found(o_found), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow of the block's registers and memories.
    logic [19:0] cell_sz;
    logic [4:0]  grid_x, grid_y, grid_z;
    logic [19:0] pos_mem [MAX_PARTICLES][3];
    int          hash_mem [MAX_PARTICLES];
    int          order_mem [MAX_PARTICLES];
    int          bin_lo [MAX_CELLS];
    int          bin_hi [MAX_CELLS];
    int          bin_cnt [MAX_CELLS];
    int          built_total;

    t_cmd pending_cmds[$];
    t_hit expected_hits[$];
    t_cmd cur_cmd;
    int   idle_pct;
    int   errors;
    int   cmds_accepted;
    int   hits_seen;
    int   full_queries;
    int   stall_count;
    int   filled;

    function automatic int dim(logic [4:0] g);
        if (g == 0) return 1;
        if (g > GRID_MAX) return GRID_MAX;
        return g;
    endfunction

    function automatic int coord_of(logic [19:0] p, int g);
        int sp;
        int c;
        sp = (cell_sz == 0) ? 1 : cell_sz;
        c = p / sp;
        return (c > g - 1) ? g - 1 : c;
    endfunction

    function automatic void predict_hits(t_cmd c);
        int gx, gy, gz, n, acc, h, q, cnt;
        int cx, cy, cz, nx, ny, nz;
        longint ax, ay, az, r2;
        t_hit e;
        gx = dim(grid_x);
        gy = dim(grid_y);
        gz = dim(grid_z);
        case (c.op)
            OP_LOAD: begin
                if (c.idx < MAX_PARTICLES) begin
                    pos_mem[c.idx][0] = c.px;
                    pos_mem[c.idx][1] = c.py;
                    pos_mem[c.idx][2] = c.pz;
                end
            end
            OP_BUILD: begin
                n = (c.idx > MAX_PARTICLES) ? MAX_PARTICLES : c.idx;
                built_total = n;
                for (int k = 0; k < MAX_CELLS; k++) bin_cnt[k] = 0;
                for (int i = 0; i < n; i++) begin
                    h = coord_of(pos_mem[i][2], gz) * gx * gy
                      + coord_of(pos_mem[i][1], gy) * gx + coord_of(pos_mem[i][0], gx);
                    hash_mem[i] = h;
                    if (h < MAX_CELLS) bin_cnt[h]++;
                end
                acc = 0;
                for (int k = 0; k < MAX_CELLS; k++) begin
                    bin_lo[k] = acc;
                    bin_hi[k] = acc;
                    acc += bin_cnt[k];
                end
                for (int i = 0; i < n; i++) begin
                    h = hash_mem[i];
                    if (h < MAX_CELLS) begin
                        order_mem[bin_hi[h] % MAX_PARTICLES] = i;
                        bin_hi[h]++;
                    end
                end
            end
            OP_QUERY: begin
                cnt = 0;
                if (c.idx < built_total && c.idx < MAX_PARTICLES) begin
                    cx = coord_of(pos_mem[c.idx][0], gx);
                    cy = coord_of(pos_mem[c.idx][1], gy);
                    cz = coord_of(pos_mem[c.idx][2], gz);
                    r2 = longint'(cell_sz) * longint'(cell_sz);
                    for (int dz = -1; dz <= 1; dz++)
                    for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++) begin
                        nx = cx + dx;
                        ny = cy + dy;
                        nz = cz + dz;
                        if (nx < 0 || ny < 0 || nz < 0) continue;
                        if (nx >= gx || ny >= gy || nz >= gz) continue;
                        h = nz * gx * gy + ny * gx + nx;
                        if (h >= MAX_CELLS) continue;
                        for (int j = bin_lo[h]; j < bin_hi[h] && j < MAX_PARTICLES; j++) begin
                            q = order_mem[j] % MAX_PARTICLES;
                            if (q == c.idx) continue;
                            ax = pos_mem[c.idx][0] > pos_mem[q][0] ?
                                 pos_mem[c.idx][0] - pos_mem[q][0] :
                                 pos_mem[q][0] - pos_mem[c.idx][0];
                            ay = pos_mem[c.idx][1] > pos_mem[q][1] ?
                                 pos_mem[c.idx][1] - pos_mem[q][1] :
                                 pos_mem[q][1] - pos_mem[c.idx][1];
                            az = pos_mem[c.idx][2] > pos_mem[q][2] ?
                                 pos_mem[c.idx][2] - pos_mem[q][2] :
                                 pos_mem[q][2] - pos_mem[c.idx][2];
                            if (ax >= cell_sz || ay >= cell_sz || az >= cell_sz) continue;
                            if (ax * ax + ay * ay + az * az >= r2) continue;
                            if (cnt >= NEIGHBOR_LIMIT) continue;
                            cnt++;
                            e.nbr = q[9:0];
                            e.ord = cnt[6:0];
                            e.found = 1'b1;
                            e.last = 1'b0;
                            expected_hits.push_back(e);
                        end
                    end
                end
                if (cnt == 0) begin
                    e.nbr = '0;
                    e.ord = '0;
                    e.found = 1'b0;
                    e.last = 1'b1;
                    expected_hits.push_back(e);
                end else begin
                    expected_hits[expected_hits.size() - 1].last = 1'b1;
                end
                if (cnt == NEIGHBOR_LIMIT) full_queries++;
            end
            default: ;
        endcase
    endfunction

    // Command driver: holds start until the transaction is taken, then pulls the next one.
    always @(posedge i_clk) begin
        logic take_next;
        t_cmd nxt;
        take_next = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_hits(cur_cmd);
                cmds_accepted++;
            end
            if (!(start && busy)) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = pending_cmds.pop_front();
                    cur_cmd = nxt;
                    take_next = 1'b1;
                    i_opcode <= nxt.op;
                    i_particle_index <= nxt.idx;
                    i_pos_x <= nxt.px;
                    i_pos_y <= nxt.py;
                    i_pos_z <= nxt.pz;
                end
                start <= take_next;
            end
        end
    end

    always @(posedge i_clk) begin
        t_hit e;
        if (i_rst_n && o_result_valid) begin
            hits_seen++;
            if (expected_hits.size() == 0) begin
                errors++;
                $display("%0t: unexpected result index=%0d ordinal=%0d found=%0d last=%0d",
                         $realtime, o_nbr_index, o_neighbor_ordinal, o_found, o_last);
            end else begin
                e = expected_hits.pop_front();
                if (o_nbr_index !== e.nbr) begin
                    errors++;
                    $display("%0t: nbr_index expected %0d actual %0d",
                             $realtime, e.nbr, o_nbr_index);
                end
                if (o_neighbor_ordinal !== e.ord) begin
                    errors++;
                    $display("%0t: neighbor_ordinal expected %0d actual %0d",
                             $realtime, e.ord, o_neighbor_ordinal);
                end
                if (o_found !== e.found) begin
                    errors++;
                    $display("%0t: found expected %0d actual %0d", $realtime, e.found, o_found);
                end
                if (o_last !== e.last) begin
                    errors++;
                    $display("%0t: last expected %0d actual %0d", $realtime, e.last, o_last);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction and no result.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (psel && penable) || !i_rst_n) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_cmd(t_opcode op, int idx, int x, int y, int z);
        t_cmd c;
        c.op = op;
        c.idx = idx[10:0];
        c.px = x[19:0];
        c.py = y[19:0];
        c.pz = z[19:0];
        pending_cmds.push_back(c);
    endtask

    task automatic write_reg(t_reg_idx r, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_CELL_SIZE: cell_sz = v[19:0];
            REG_GRID_X:    grid_x = v[4:0];
            REG_GRID_Y:    grid_y = v[4:0];
            default:       grid_z = v[4:0];
        endcase
    endtask

    // Drain queued commands, then let the core finish any work that makes no result.
    task automatic settle();
        while (pending_cmds.size() > 0 || start) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy || expected_hits.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid(int cs, int gx, int gy, int gz);
        write_reg(REG_CELL_SIZE, cs);
        write_reg(REG_GRID_X, gx);
        write_reg(REG_GRID_Y, gy);
        write_reg(REG_GRID_Z, gz);
    endtask

    function automatic int near(int base, int spread);
        longint v;
        v = longint'(base) + longint'($urandom_range(spread)) - longint'(spread / 2);
        if (v < 0) v = 0;
        if (v > 20'hFFFFF) v = 20'hFFFFF;
        return int'(v);
    endfunction

    // One cluster of particles, an index over a count of slots, queries, ignored commands and some stale loads.
    task automatic run_scene(int n, int spread);
        int bx, by, bz;
        int b;
        bx = int'($urandom_range(20'hFFFFF));
        by = int'($urandom_range(20'hFFFFF));
        bz = int'($urandom_range(20'hFFFFF));
        for (int i = 0; i < n; i++)
            push_cmd(OP_LOAD, i, near(bx, spread), near(by, spread), near(bz, spread));
        if (n > filled) filled = n;
        b = ($urandom_range(3) == 0) ? $urandom_range(filled) : n;
        push_cmd(OP_BUILD, b, $urandom, $urandom, $urandom);
        for (int i = 0; i < n / 2 + 3; i++) begin
            case ($urandom_range(9))
                0: push_cmd(OP_NONE, $urandom, $urandom, $urandom, $urandom);
                1: push_cmd(OP_LOAD, $urandom_range(2047, 1024), $urandom, $urandom,
                            $urandom);
                2: push_cmd(OP_LOAD, $urandom_range(filled - 1), near(bx, spread),
                            near(by, spread), near(bz, spread));
                3: push_cmd(OP_QUERY, $urandom_range(2047), $urandom, $urandom, $urandom);
                default: push_cmd(OP_QUERY, $urandom_range(b + 1), $urandom, $urandom,
                                  $urandom);
            endcase
        end
        settle();
    endtask

    initial begin
        int cs;
        start = 1'b0;
        i_opcode = OP_NONE;
        i_particle_index = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cell_sz = 20'd1024;
        grid_x = 5'd16;
        grid_y = 5'd16;
        grid_z = 5'd16;
        built_total = 0;
        idle_pct = 36;
        errors = 0;
        cmds_accepted = 0;
        hits_seen = 0;
        full_queries = 0;
        filled = 0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: queries before any index, field extremes, ignored opcode and slots.
        push_cmd(OP_QUERY, 0, 0, 0, 0);
        push_cmd(OP_NONE, 2047, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        push_cmd(OP_LOAD, 1024, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        push_cmd(OP_LOAD, 2047, 20'h12345, 20'h54321, 20'hABCDE);
        push_cmd(OP_LOAD, 0, 0, 0, 0);
        push_cmd(OP_LOAD, 1, 20'd300, 20'd200, 20'd100);
        push_cmd(OP_LOAD, 2, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        push_cmd(OP_LOAD, 3, 20'hFFC00, 20'hFFFFF, 20'hFFA00);
        push_cmd(OP_LOAD, 4, 20'd1023, 20'd1023, 20'd1024);
        push_cmd(OP_LOAD, 1023, 20'h5A5A5, 20'hA5A5A, 20'h0F0F0);
        push_cmd(OP_BUILD, 5, 0, 0, 0);
        for (int i = 0; i < 5; i++) push_cmd(OP_QUERY, i, 0, 0, 0);
        push_cmd(OP_QUERY, 5, 0, 0, 0);
        push_cmd(OP_QUERY, 1023, 0, 0, 0);
        push_cmd(OP_QUERY, 2047, 0, 0, 0);
        // Stale index: move particle 1 next to particle 4 without rebuilding.
        push_cmd(OP_LOAD, 1, 20'd1000, 20'd1000, 20'd1000);
        push_cmd(OP_QUERY, 1, 0, 0, 0);
        push_cmd(OP_QUERY, 4, 0, 0, 0);
        push_cmd(OP_BUILD, 0, 0, 0, 0);
        push_cmd(OP_QUERY, 0, 0, 0, 0);
        settle();
        filled = 5;

        // Register extremes, including the zero and over-range values that get clamped.
        set_grid(1, 1, 1, 1);
        run_scene(12, 4);
        set_grid(0, 0, 31, 17);
        run_scene(10, 3);
        set_grid(20'hFFFFF, 16, 16, 16);
        run_scene(70, 20000);
        idle_pct = 0;
        set_grid(1024, 16, 16, 16);
        run_scene(40, 3000);
        set_grid(4096, 3, 5, 2);
        run_scene(30, 20000);
        idle_pct = 36;
        while (cmds_accepted < 310) begin
            case ($urandom_range(3))
                0: cs = $urandom_range(8);
                1: cs = $urandom_range(20'hFFFFF);
                default: cs = $urandom_range(4096, 256);
            endcase
            set_grid(cs, $urandom_range(31), $urandom_range(31), $urandom_range(31));
            run_scene($urandom_range(40, 4), $urandom_range(4 * cs + 2));
        end
        settle();

        $display("Covered %0d commands and %0d results, %0d queries at the neighbor limit.",
                 cmds_accepted, hits_seen, full_queries);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
